// ===== design/isms_pkg.sv =====
`timescale 1ns / 1ps
// Package for the interval statistics monitor: defaults, codes and sequencer states.
package isms_pkg;

	localparam int COUNT_BITS_DEF    = 24;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int INTERVAL_BITS_DEF = 32;

	localparam int VAR_W = 64;
	localparam int CNT_W = $clog2(VAR_W + 1);
	localparam int SQRT_STEPS = VAR_W / 2;
	localparam int SQ_STEPS   = VAR_W / 2;

	localparam logic [VAR_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

	localparam logic [23:0] SAMPLE_COUNT_RST   = 24'd1000;
	localparam logic [31:0] NOMINAL_PERIOD_RST = 32'd1000;

	localparam logic [0:0] REG_SAMPLE_COUNT   = 1'b0;
	localparam logic [0:0] REG_NOMINAL_PERIOD = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_ARM    = 1'b1;

	typedef enum logic [14:0] {
		ST_IDLE    = 15'h0001,
		ST_CMP_MAX = 15'h0002,
		ST_CMP_MIN = 15'h0004,
		ST_MAG     = 15'h0008,
		ST_MAG_N   = 15'h0010,
		ST_DIV_M   = 15'h0020,
		ST_UPD_M   = 15'h0040,
		ST_DIV_V   = 15'h0080,
		ST_SUB_V   = 15'h0100,
		ST_SQ      = 15'h0200,
		ST_MUL_N   = 15'h0400,
		ST_ADD_V   = 15'h0800,
		ST_CHK     = 15'h1000,
		ST_SQRT    = 15'h2000,
		ST_FIN     = 15'h4000
	} isms_state_t;

endpackage

// ===== design/interval_stats_monitor.sv =====
`timescale 1ns / 1ps
// Interval statistics monitor: running mean, variance, min and max over a run of samples.
// An arm word is taken in idle and reseeds the statistics. A sample word is worked by the
// bit-serial divides and multiplies through the single shared adder; the sample that
// completes the run adds the square root and the result load. One word is worked at a time.
// Reset: idle and disarmed, sample_count and nominal_period at 1000, no result pending.
module interval_stats_monitor #(
	parameter int COUNT_BITS    = isms_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS     = isms_pkg::FRAC_BITS_DEF,
	parameter int INTERVAL_BITS = isms_pkg::INTERVAL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_ready,
	input  logic        cmd,
	input  logic [31:0] interval,

	output logic        res_valid,
	input  logic        res_ready,
	output logic [47:0] mean_period,
	output logic [47:0] std_dev,
	output logic [31:0] max_period,
	output logic [23:0] max_at,
	output logic [31:0] min_period,
	output logic [23:0] min_at,
	output logic        var_saturated,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int VW = isms_pkg::VAR_W;
	localparam int CW = isms_pkg::CNT_W;
	localparam int MW = INTERVAL_BITS + FRAC_BITS;
	localparam int W  = VW + COUNT_BITS + 1;

	isms_pkg::isms_state_t state_q;

	logic [23:0]              sample_count_q;
	logic [31:0]              nominal_q;
	logic                     armed_q;
	logic [COUNT_BITS-1:0]    idx_q;
	logic [MW-1:0]            mean_q;
	logic [VW-1:0]            var_q;
	logic [INTERVAL_BITS-1:0] largest_q;
	logic [INTERVAL_BITS-1:0] smallest_q;
	logic [COUNT_BITS-1:0]    largest_idx_q;
	logic [COUNT_BITS-1:0]    smallest_idx_q;
	logic                     sat_q;

	logic [INTERVAL_BITS-1:0] t_q;
	logic [W-1:0]             a_q;
	logic [W-1:0]             r_q;
	logic [MW-1:0]            dm_q;
	logic                     neg_q;
	logic [VW-1:0]            term1_q;
	logic [VW-1:0]            sq_q;
	logic                     t2sat_q;
	logic [CW-1:0]            cnt_q;

	logic        res_valid_q;
	logic [47:0] mean_period_q;
	logic [47:0] std_dev_q;
	logic [31:0] max_period_q;
	logic [23:0] max_at_q;
	logic [31:0] min_period_q;
	logic [23:0] min_at_q;
	logic        var_sat_q;

	logic [W-1:0]            alu_a;
	logic [W-1:0]            alu_b;
	logic                    alu_sub;
	logic [W:0]              alu_sum;
	logic                    alu_co;
	logic [W-1:0]            alu_res;

	logic [MW-1:0]           tq_w;
	logic [MW-1:0]           seed_mean;
	logic [COUNT_BITS:0]     idx_p1;
	logic [COUNT_BITS:0]     den;
	logic                    div_msb;
	logic [VW-1:0]           dm_ext;
	logic                    dm_big;
	logic                    t2_ovf;
	logic [VW-1:0]           term2;
	logic                    cnt_last;
	logic                    cfg_wr;
	logic [VW-1:0]           mean_ext;
	logic [31:0]             max_at_ext;
	logic [31:0]             min_at_ext;

	assign item_ready = (state_q == isms_pkg::ST_IDLE);
	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite;

	assign tq_w      = {t_q, {FRAC_BITS{1'b0}}};
	assign seed_mean = {nominal_q[INTERVAL_BITS-1:0], {FRAC_BITS{1'b0}}};
	assign idx_p1    = {1'b0, idx_q} + (COUNT_BITS+1)'(1);
	assign den       = (state_q == isms_pkg::ST_DIV_M) ? idx_p1 : {1'b0, idx_q};
	assign div_msb   = (state_q == isms_pkg::ST_DIV_V) ? a_q[VW-1] : a_q[MW-1];
	assign dm_ext    = VW'(dm_q);
	assign dm_big    = (dm_ext[VW-1:32] != '0);
	assign t2_ovf    = t2sat_q || (r_q[W-1:VW] != '0);
	assign term2     = t2_ovf ? '1 : r_q[VW-1:0];
	assign cnt_last  = (cnt_q == CW'(1));

	// shared adder / subtractor
	assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {W{alu_sub}}} + (W+1)'(alu_sub);
	assign alu_co  = alu_sum[W];
	assign alu_res = alu_sum[W-1:0];

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q) inside
			isms_pkg::ST_CMP_MAX: begin
				alu_a   = W'(largest_q);
				alu_b   = W'(t_q);
				alu_sub = 1'b1;
			end
			isms_pkg::ST_CMP_MIN: begin
				alu_a   = W'(t_q);
				alu_b   = W'(smallest_q);
				alu_sub = 1'b1;
			end
			isms_pkg::ST_MAG: begin
				alu_a   = W'(tq_w);
				alu_b   = W'(mean_q);
				alu_sub = 1'b1;
			end
			isms_pkg::ST_MAG_N: begin
				alu_a   = W'(mean_q);
				alu_b   = W'(tq_w);
				alu_sub = 1'b1;
			end
			isms_pkg::ST_DIV_M, isms_pkg::ST_DIV_V: begin
				alu_a   = {r_q[W-2:0], div_msb};
				alu_b   = W'(den);
				alu_sub = 1'b1;
			end
			isms_pkg::ST_UPD_M: begin
				alu_a   = W'(mean_q);
				alu_b   = W'(a_q[MW-1:0]);
				alu_sub = neg_q;
			end
			isms_pkg::ST_SUB_V: begin
				alu_a   = W'(var_q);
				alu_b   = W'(a_q[VW-1:0]);
				alu_sub = 1'b1;
			end
			isms_pkg::ST_SQ: begin
				alu_a = {r_q[W-2:0], 1'b0};
				alu_b = a_q[31] ? W'(dm_ext[31:0]) : '0;
			end
			isms_pkg::ST_MUL_N: begin
				alu_a = {r_q[W-2:0], 1'b0};
				alu_b = a_q[COUNT_BITS] ? W'(sq_q) : '0;
			end
			isms_pkg::ST_ADD_V: begin
				alu_a = W'(term1_q);
				alu_b = W'(term2);
			end
			isms_pkg::ST_CHK: begin
				alu_a   = W'(idx_q);
				alu_b   = W'(sample_count_q);
				alu_sub = 1'b1;
			end
			isms_pkg::ST_SQRT: begin
				alu_a   = W'(a_q[VW-1:0]);
				alu_b   = W'(r_q[VW-1:0] | sq_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= isms_pkg::SAMPLE_COUNT_RST;
			nominal_q      <= isms_pkg::NOMINAL_PERIOD_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				isms_pkg::REG_SAMPLE_COUNT:   sample_count_q <= pwdata[23:0];
				isms_pkg::REG_NOMINAL_PERIOD: nominal_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			isms_pkg::REG_SAMPLE_COUNT:   prdata = 32'(sample_count_q);
			isms_pkg::REG_NOMINAL_PERIOD: prdata = nominal_q;
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= isms_pkg::ST_IDLE;
			armed_q        <= 1'b0;
			idx_q          <= COUNT_BITS'(1);
			mean_q         <= {isms_pkg::NOMINAL_PERIOD_RST[INTERVAL_BITS-1:0],
				{FRAC_BITS{1'b0}}};
			var_q          <= '0;
			largest_q      <= isms_pkg::NOMINAL_PERIOD_RST[INTERVAL_BITS-1:0];
			smallest_q     <= isms_pkg::NOMINAL_PERIOD_RST[INTERVAL_BITS-1:0];
			largest_idx_q  <= '0;
			smallest_idx_q <= '0;
			sat_q          <= 1'b0;
			t_q            <= '0;
			a_q            <= '0;
			r_q            <= '0;
			dm_q           <= '0;
			neg_q          <= 1'b0;
			term1_q        <= '0;
			sq_q           <= '0;
			t2sat_q        <= 1'b0;
			cnt_q          <= '0;
		end else begin
			unique case (state_q) inside
				isms_pkg::ST_IDLE: begin
					if (item_valid) begin
						if (cmd == isms_pkg::CMD_ARM) begin
							armed_q        <= 1'b1;
							idx_q          <= COUNT_BITS'(1);
							mean_q         <= seed_mean;
							var_q          <= '0;
							largest_q      <= nominal_q[INTERVAL_BITS-1:0];
							smallest_q     <= nominal_q[INTERVAL_BITS-1:0];
							largest_idx_q  <= '0;
							smallest_idx_q <= '0;
							sat_q          <= 1'b0;
						end else if (armed_q) begin
							t_q     <= interval[INTERVAL_BITS-1:0];
							state_q <= isms_pkg::ST_CMP_MAX;
						end
					end
				end
				isms_pkg::ST_CMP_MAX: begin
					if (!alu_co) begin
						largest_q     <= t_q;
						largest_idx_q <= idx_q;
					end
					state_q <= isms_pkg::ST_CMP_MIN;
				end
				isms_pkg::ST_CMP_MIN: begin
					if (!alu_co) begin
						smallest_q     <= t_q;
						smallest_idx_q <= idx_q;
					end
					state_q <= isms_pkg::ST_MAG;
				end
				isms_pkg::ST_MAG: begin
					if (alu_co) begin
						a_q     <= W'(alu_res[MW-1:0]);
						neg_q   <= 1'b0;
						r_q     <= '0;
						cnt_q   <= CW'(MW);
						state_q <= isms_pkg::ST_DIV_M;
					end else begin
						state_q <= isms_pkg::ST_MAG_N;
					end
				end
				isms_pkg::ST_MAG_N: begin
					a_q     <= W'(alu_res[MW-1:0]);
					neg_q   <= 1'b1;
					r_q     <= '0;
					cnt_q   <= CW'(MW);
					state_q <= isms_pkg::ST_DIV_M;
				end
				isms_pkg::ST_DIV_M, isms_pkg::ST_DIV_V: begin
					// restoring divide, one quotient bit per cycle
					r_q   <= alu_co ? alu_res : {r_q[W-2:0], div_msb};
					a_q   <= {a_q[W-2:0], alu_co};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_last) begin
						state_q <= (state_q == isms_pkg::ST_DIV_M) ?
							isms_pkg::ST_UPD_M : isms_pkg::ST_SUB_V;
					end
				end
				isms_pkg::ST_UPD_M: begin
					mean_q  <= alu_res[MW-1:0];
					dm_q    <= a_q[MW-1:0];
					a_q     <= W'(var_q);
					r_q     <= '0;
					cnt_q   <= CW'(VW);
					state_q <= isms_pkg::ST_DIV_V;
				end
				isms_pkg::ST_SUB_V: begin
					term1_q <= alu_res[VW-1:0];
					if (dm_big) begin
						t2sat_q <= 1'b1;
						state_q <= isms_pkg::ST_ADD_V;
					end else begin
						t2sat_q <= 1'b0;
						a_q     <= W'(dm_ext[31:0]);
						r_q     <= '0;
						cnt_q   <= CW'(isms_pkg::SQ_STEPS);
						state_q <= isms_pkg::ST_SQ;
					end
				end
				isms_pkg::ST_SQ: begin
					if (cnt_last) begin
						sq_q    <= alu_res[VW-1:0];
						r_q     <= '0;
						a_q     <= W'(idx_p1);
						cnt_q   <= CW'(COUNT_BITS + 1);
						state_q <= isms_pkg::ST_MUL_N;
					end else begin
						r_q   <= alu_res;
						a_q   <= {a_q[W-2:0], 1'b0};
						cnt_q <= cnt_q - CW'(1);
					end
				end
				isms_pkg::ST_MUL_N: begin
					r_q   <= alu_res;
					a_q   <= {a_q[W-2:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_last) begin
						state_q <= isms_pkg::ST_ADD_V;
					end
				end
				isms_pkg::ST_ADD_V: begin
					var_q   <= alu_res[VW] ? '1 : alu_res[VW-1:0];
					sat_q   <= sat_q | t2_ovf | alu_res[VW];
					state_q <= isms_pkg::ST_CHK;
				end
				isms_pkg::ST_CHK: begin
					if (alu_co || (&idx_q)) begin
						armed_q <= 1'b0;
						a_q     <= W'(var_q);
						r_q     <= '0;
						sq_q    <= isms_pkg::SQRT_BIT0;
						cnt_q   <= CW'(isms_pkg::SQRT_STEPS);
						state_q <= isms_pkg::ST_SQRT;
					end else begin
						idx_q   <= idx_q + COUNT_BITS'(1);
						state_q <= isms_pkg::ST_IDLE;
					end
				end
				isms_pkg::ST_SQRT: begin
					// res + bit never carries: res | bit
					if (alu_co) begin
						a_q <= alu_res;
						r_q <= W'((r_q[VW-1:0] >> 1) | sq_q);
					end else begin
						r_q <= W'(r_q[VW-1:0] >> 1);
					end
					sq_q  <= sq_q >> 2;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_last) begin
						state_q <= isms_pkg::ST_FIN;
					end
				end
				isms_pkg::ST_FIN: begin
					if (!res_valid_q || res_ready) begin
						state_q <= isms_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= isms_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign mean_ext   = VW'(mean_q);
	assign max_at_ext = 32'(largest_idx_q);
	assign min_at_ext = 32'(smallest_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == isms_pkg::ST_FIN && (!res_valid_q || res_ready)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == isms_pkg::ST_FIN && (!res_valid_q || res_ready)) begin
			mean_period_q <= mean_ext[47:0];
			std_dev_q     <= r_q[47:0];
			max_period_q  <= 32'(largest_q);
			max_at_q      <= max_at_ext[23:0];
			min_period_q  <= 32'(smallest_q);
			min_at_q      <= min_at_ext[23:0];
			var_sat_q     <= sat_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign mean_period   = mean_period_q;
	assign std_dev       = std_dev_q;
	assign max_period    = max_period_q;
	assign max_at        = max_at_q;
	assign min_period    = min_period_q;
	assign min_at        = min_at_q;
	assign var_saturated = var_sat_q;

	a_arm_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && cmd == isms_pkg::CMD_ARM
		|=> armed_q && idx_q == COUNT_BITS'(1) && var_q == '0 && !sat_q)
		else $error("arm did not reseed the statistics");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		smallest_q <= largest_q)
		else $error("minimum above maximum");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 && largest_idx_q <= idx_q && smallest_idx_q <= idx_q)
		else $error("sample index out of order");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == isms_pkg::ST_FIN) && !armed_q)
		else $error("result raised outside the final step");

endmodule
